FILE: rtl/core/nppw_pkg.sv
`timescale 1ns / 1ps

package nppw_pkg;

    localparam int REG_W     = 13;
    localparam int POS_W     = 16;
    localparam int CHAN_W    = 8;
    localparam int RGB_W     = 3 * CHAN_W;
    localparam int PIDX_W    = 8;
    localparam int OFFSET_W  = 26;
    localparam int DIST_W    = 18;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USED_W = OFFSET_W + PIDX_W + 4 * CHAN_W;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 13'd320;
    localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 13'd200;

    localparam logic [RGB_W-1:0] PAL_ROM [0:255] = '{
        24'h000000, 24'h800000, 24'h008000, 24'h808000,
        24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
        24'hc0dcc0, 24'ha6caf0, 24'h2a3faa, 24'h2a3fff,
        24'h2a5f00, 24'h2a5f55, 24'h2a5faa, 24'h2a5fff,
        24'h2a7f00, 24'h2a7f55, 24'h2a7faa, 24'h2a7fff,
        24'h2a9f00, 24'h2a9f55, 24'h2a9faa, 24'h2a9fff,
        24'h2abf00, 24'h2abf55, 24'h2abfaa, 24'h2abfff,
        24'h2adf00, 24'h2adf55, 24'h2adfaa, 24'h2adfff,
        24'h2aff00, 24'h2aff55, 24'h2affaa, 24'h2affff,
        24'h550000, 24'h550055, 24'h5500aa, 24'h5500ff,
        24'h551f00, 24'h551f55, 24'h551faa, 24'h551fff,
        24'h553f00, 24'h553f55, 24'h553faa, 24'h553fff,
        24'h555f00, 24'h555f55, 24'h555faa, 24'h555fff,
        24'h557f00, 24'h557f55, 24'h557faa, 24'h557fff,
        24'h559f00, 24'h559f55, 24'h559faa, 24'h559fff,
        24'h55bf00, 24'h55bf55, 24'h55bfaa, 24'h55bfff,
        24'h55df00, 24'h55df55, 24'h55dfaa, 24'h55dfff,
        24'h55ff00, 24'h55ff55, 24'h55ffaa, 24'h55ffff,
        24'h7f0000, 24'h7f0055, 24'h7f00aa, 24'h7f00ff,
        24'h7f1f00, 24'h7f1f55, 24'h7f1faa, 24'h7f1fff,
        24'h7f3f00, 24'h7f3f55, 24'h7f3faa, 24'h7f3fff,
        24'h7f5f00, 24'h7f5f55, 24'h7f5faa, 24'h7f5fff,
        24'h7f7f00, 24'h7f7f55, 24'h7f7faa, 24'h7f7fff,
        24'h7f9f00, 24'h7f9f55, 24'h7f9faa, 24'h7f9fff,
        24'h7fbf00, 24'h7fbf55, 24'h7fbfaa, 24'h7fbfff,
        24'h7fdf00, 24'h7fdf55, 24'h7fdfaa, 24'h7fdfff,
        24'h7fff00, 24'h7fff55, 24'h7fffaa, 24'h7fffff,
        24'haa0000, 24'haa0055, 24'haa00aa, 24'haa00ff,
        24'haa1f00, 24'haa1f55, 24'haa1faa, 24'haa1fff,
        24'haa3f00, 24'haa3f55, 24'haa3faa, 24'haa3fff,
        24'haa5f00, 24'haa5f55, 24'haa5faa, 24'haa5fff,
        24'haa7f00, 24'haa7f55, 24'haa7faa, 24'haa7fff,
        24'haa9f00, 24'haa9f55, 24'haa9faa, 24'haa9fff,
        24'haabf00, 24'haabf55, 24'haabfaa, 24'haabfff,
        24'haadf00, 24'haadf55, 24'haadfaa, 24'haadfff,
        24'haaff00, 24'haaff55, 24'haaffaa, 24'haaffff,
        24'hd40000, 24'hd40055, 24'hd400aa, 24'hd400ff,
        24'hd41f00, 24'hd41f55, 24'hd41faa, 24'hd41fff,
        24'hd43f00, 24'hd43f55, 24'hd43faa, 24'hd43fff,
        24'hd45f00, 24'hd45f55, 24'hd45faa, 24'hd45fff,
        24'hd47f00, 24'hd47f55, 24'hd47faa, 24'hd47fff,
        24'hd49f00, 24'hd49f55, 24'hd49faa, 24'hd49fff,
        24'hd4bf00, 24'hd4bf55, 24'hd4bfaa, 24'hd4bfff,
        24'hd4df00, 24'hd4df55, 24'hd4dfaa, 24'hd4dfff,
        24'hd4ff00, 24'hd4ff55, 24'hd4ffaa, 24'hd4ffff,
        24'hff0055, 24'hff00aa, 24'hff1f00, 24'hff1f55,
        24'hff1faa, 24'hff1fff, 24'hff3f00, 24'hff3f55,
        24'hff3faa, 24'hff3fff, 24'hff5f00, 24'hff5f55,
        24'hff5faa, 24'hff5fff, 24'hff7f00, 24'hff7f55,
        24'hff7faa, 24'hff7fff, 24'hff9f00, 24'hff9f55,
        24'hff9faa, 24'hff9fff, 24'hffbf00, 24'hffbf55,
        24'hffbfaa, 24'hffbfff, 24'hffdf00, 24'hffdf55,
        24'hffdfaa, 24'hffdfff, 24'hffff55, 24'hffffaa,
        24'hccccff, 24'hffccff, 24'h33ffff, 24'h66ffff,
        24'h99ffff, 24'hccffff, 24'h007f00, 24'h007f55,
        24'h007faa, 24'h007fff, 24'h009f00, 24'h009f55,
        24'h009faa, 24'h009fff, 24'h00bf00, 24'h00bf55,
        24'h00bfaa, 24'h00bfff, 24'h00df00, 24'h00df55,
        24'h00dfaa, 24'h00dfff, 24'h00ff55, 24'h00ffaa,
        24'h2a0000, 24'h2a0055, 24'h2a00aa, 24'h2a00ff,
        24'h2a1f00, 24'h2a1f55, 24'h2a1faa, 24'h2a1fff,
        24'h2a3f00, 24'h2a3f55, 24'hfffbf0, 24'ha0a0a4,
        24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
        24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
    };

    function automatic logic [2*CHAN_W-1:0] sq_diff(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b
    );
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

endpackage

FILE: rtl/core/nearest_palette_pixel_writer.sv
`timescale 1ns / 1ps

// pixel write to frame buffer write with nearest palette color
// s_axis carries one pixel write per transaction (position and rgba color),
// m_axis carries one frame buffer write per kept pixel: byte offset
// (y*frame_width+x)*4, chosen palette index and rgb, and the input alpha.
// pixels with a negative coordinate or one at or beyond the frame size are
// dropped: the input stays ready after such a transaction.
// a kept pixel runs through the palette one entry per cycle on a single
// distance unit (three 8 bit squares, an add and a compare), so
// s_axis_tready stays low from the transaction until the result is loaded
// into the output register: the block takes no new pixel before it is
// through with the last one. the result sits in an output register: when the
// receiver stalls, the block waits with the next result until the register
// is free. the user writes frame_width and frame_height on the cfg port only
// while idle; the block does not enforce it. reset (synchronous, active low)
// empties the output register, returns the sequencer to idle and sets the
// frame to 320 x 200.
module nearest_palette_pixel_writer
    import nppw_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [REG_W-1:0]        i_cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // pos_x, pos_y, in_red, in_green, in_blue, in_alpha
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // byte_offset, palette_index, out_red, out_green, out_blue, out_alpha, zero pad
    output logic [OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [REG_W-1:0]      r_width, r_height;
    logic [REG_W-1:0]      r_x, r_y;
    logic [CHAN_W-1:0]     r_red, r_green, r_blue, r_alpha;
    logic [2*REG_W-1:0]    r_prod;

    logic [IDX_W-1:0]      r_idx;
    logic                  r_issued;
    logic                  r_vld_a, r_last_a, r_first_a;
    logic [IDX_W-1:0]      r_idx_a;
    logic [DIST_W-1:0]     r_dist_a;
    logic [IDX_W-1:0]      r_best_idx;
    logic [DIST_W-1:0]     r_best_dist;

    logic                  r_out_vld;
    logic [OUT_USED_W-1:0] r_out_data;

    logic [POS_W-1:0]      in_x, in_y;
    logic                  in_fire, in_keep, issue, out_load;
    logic [RGB_W-1:0]      scan_rgb, best_rgb;
    logic [DIST_W-1:0]     scan_dist;
    logic [OFFSET_W-3:0]   pix_addr;

    assign in_x    = s_axis_tdata[15:0];
    assign in_y    = s_axis_tdata[31:16];
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_keep = !in_x[POS_W-1] && !in_y[POS_W-1]
                  && (in_x < {{(POS_W-REG_W){1'b0}}, r_width})
                  && (in_y < {{(POS_W-REG_W){1'b0}}, r_height});

    assign s_axis_tready = (r_state == S_IDLE);
    assign issue         = (r_state == S_SCAN) && !r_issued;
    assign out_load      = (r_state == S_DONE) && (!r_out_vld || m_axis_tready);

    // distance unit, one palette entry per cycle
    assign scan_rgb  = PAL_ROM[PIDX_W'(r_idx)];
    assign scan_dist = DIST_W'(sq_diff(scan_rgb[23:16], r_red))
                     + DIST_W'(sq_diff(scan_rgb[15:8], r_green))
                     + DIST_W'(sq_diff(scan_rgb[7:0], r_blue));

    assign best_rgb = PAL_ROM[PIDX_W'(r_best_idx)];
    // offset wraps at 2^26, so only the low 24 bits of the pixel address count
    assign pix_addr = r_prod[OFFSET_W-3:0] + {{(OFFSET_W-2-REG_W){1'b0}}, r_x};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && in_keep) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_vld_a && r_last_a) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_width   <= FRAME_WIDTH_RST;
            r_height  <= FRAME_HEIGHT_RST;
            r_issued  <= 1'b0;
            r_vld_a   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_issued <= 1'b0;
            end else if (issue && r_idx == LAST_IDX) begin
                r_issued <= 1'b1;
            end
            r_vld_a <= issue;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            // kept pixels fit the 13 bit frame registers
            r_x     <= in_x[REG_W-1:0];
            r_y     <= in_y[REG_W-1:0];
            r_red   <= s_axis_tdata[39:32];
            r_green <= s_axis_tdata[47:40];
            r_blue  <= s_axis_tdata[55:48];
            r_alpha <= s_axis_tdata[63:56];
            r_idx   <= '0;
        end else if (issue) begin
            r_idx <= r_idx + 1'b1;
        end
        r_prod    <= r_y * r_width;
        r_idx_a   <= r_idx;
        r_dist_a  <= scan_dist;
        r_last_a  <= (r_idx == LAST_IDX);
        r_first_a <= (r_idx == '0);
        // strict compare keeps the lowest index on equal distances
        if (r_vld_a && (r_first_a || r_dist_a < r_best_dist)) begin
            r_best_idx  <= r_idx_a;
            r_best_dist <= r_dist_a;
        end
        if (out_load) begin
            r_out_data <= {r_alpha, best_rgb[7:0], best_rgb[15:8], best_rgb[23:16],
                           PIDX_W'(r_best_idx), pix_addr, 2'b00};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, r_out_data};

endmodule

FILE: rtl/core/nppw_checker.sv
`timescale 1ns / 1ps

module nppw_checker
    import nppw_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds its data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // an idle input only goes busy through a transaction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
        else $error("input went busy without a transaction");

    // the palette scan lies between acceptance and result, so no result follows at once
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // offset is word aligned and pad bits stay zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] == 2'b00
                       && m_axis_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
        else $error("bad result layout");

endmodule

bind nearest_palette_pixel_writer nppw_checker u_nppw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
